// File: rtl/kart_pkg.sv
// ----------------------------------------------------------------------------
// kart_pkg: shared types and constants of the key auto-repeat tracker
// Item codes, result kinds, sequencer states and the command that passes
// results to the output stage.
// ----------------------------------------------------------------------------
package kart_pkg;

  // Input item kind
  typedef enum logic {
    REQ_PRESS = 1'b0,
    REQ_TICK  = 1'b1
  } kart_req_t;

  // Press action codes
  typedef enum logic [1:0] {
    ACT_INSTANT = 2'd0,
    ACT_HOLD    = 2'd1,
    ACT_REPEAT  = 2'd2,
    ACT_RELEASE = 2'd3
  } kart_action_t;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_TAP     = 2'd0,
    KIND_HOLD    = 2'd1,
    KIND_RELEASE = 2'd2
  } kart_kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_REL_SCAN,
    S_PRESS_ACT,
    S_TICK_SCAN,
    S_TICK_MOD,
    S_FLUSH
  } kart_state_t;

  // Result command from the sequencer to the output stage
  typedef struct packed {
    logic       push;
    logic       flush;
    kart_kind_t kind;
    logic [7:0] key;
  } kart_push_t;

  localparam logic [31:0] TICK_MIN_MS  = 32'd20;
  localparam logic [15:0] PERIOD_RESET = 16'd100;
  localparam int          MAX_TAPS     = 8;
  localparam int          TAP_W        = $clog2(MAX_TAPS + 1);
  localparam int          DIV_STEPS    = 32;

endpackage

// File: rtl/kart_mod.sv
// ----------------------------------------------------------------------------
// kart_mod: iterative remainder unit
// Restoring division of a 32-bit value by a 16-bit divisor, one quotient bit
// per cycle; gives the remainder with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module kart_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] rem
);
  import kart_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      quo;
  logic [15:0]      part;
  logic [15:0]      dvs;
  logic [16:0]      trial;
  logic [16:0]      trial_sub;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial     = {part, quo[31]};
    trial_sub = trial - {1'b0, dvs};
  end

  // Control: count the steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then advance one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      dvs  <= divisor;
      part <= '0;
    end else if (busy) begin
      quo <= {quo[30:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        part <= trial_sub[15:0];
      end else begin
        part <= trial[15:0];
      end
    end
  end

  assign rem = part;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("remainder unit restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("done without a finished division");

endmodule

// File: rtl/kart_out.sv
// ----------------------------------------------------------------------------
// kart_out: result output stage
// Holds back one result so that the final result of an item can be marked,
// and drives the registered result strobe and fields.
// ----------------------------------------------------------------------------
module kart_out (
  input  logic                clk,
  input  logic                rst,
  input  kart_pkg::kart_push_t cmd,
  output logic                out_valid,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_key,
  output logic                out_last
);
  import kart_pkg::*;

  logic       pend_valid;
  kart_kind_t pend_kind;
  logic [7:0] pend_key;
  logic       emit;

  // Release the pending result when a newer one arrives or the item ends
  assign emit = (cmd.push || cmd.flush) && pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= emit;
      if (cmd.push) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Hold the pending result and present the released one
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      pend_kind <= cmd.kind;
      pend_key  <= cmd.key;
    end
    if (emit) begin
      out_kind <= pend_kind;
      out_key  <= pend_key;
      out_last <= cmd.flush;
    end
  end

  a_push_flush_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.flush))
    else $error("push and flush in the same cycle");
  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> !pend_valid)
    else $error("pending result survived a flush");
  a_last_from_flush: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> $past(cmd.flush))
    else $error("last result not caused by a flush");

endmodule

// File: rtl/key_auto_repeat_tracker.sv
// ----------------------------------------------------------------------------
// key_auto_repeat_tracker: held-key and typematic repeat tracker
// Walks a small key table under a sequencer; one shared iterative remainder
// unit realigns the due times of repeating keys on a tick.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A press walks the
// table one slot per cycle to release its key, then acts on its action and
// ends with a flush step. A tick that is skipped leaves busy low. Any other
// tick walks the slots one per cycle and, for each due repeating key (at most
// eight), runs the shared 32-step remainder unit, which holds the walk until
// the remainder is done. Each result is shown for one cycle with out_valid and
// cannot be held off; the last result of a transaction has out_last set and
// is shown in the first cycle with busy low again.
// repeat_period_ms may be written only while busy is low; a period of zero
// acts as one.
module key_auto_repeat_tracker #(
  parameter int MAX_KEYS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [7:0]  key_code,
  input  logic [1:0]  press_action,
  input  logic [31:0] now_ms,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_key,
  output logic        out_last
);
  import kart_pkg::*;

  localparam int SLOT_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  kart_state_t  state;
  kart_state_t  state_next;

  // Table
  logic [MAX_KEYS-1:0] held_valid;
  logic [MAX_KEYS-1:0] repeat_valid;
  logic [7:0]          held_key [MAX_KEYS];
  logic [31:0]         repeat_due_ms [MAX_KEYS];
  logic [31:0]         last_tick_ms;
  logic                table_changed;
  logic [15:0]         repeat_period_ms;

  // Current transaction
  kart_req_t    req_q;
  kart_action_t action_q;
  logic [7:0]   key_q;
  logic [31:0]  now_q;
  logic [SLOT_W-1:0] slot;
  logic [TAP_W-1:0]  tap_cnt;

  logic              slot_last;
  logic              key_hit;
  logic [31:0]       late;
  logic              tap_due;
  logic              tick_skip;
  logic [15:0]       period_eff;
  logic              free_any;
  logic [SLOT_W-1:0] free_idx;
  logic              add_entry;

  kart_push_t  push;
  logic        mod_start;
  logic        mod_done;
  logic [15:0] mod_rem;

  // Slot and timing decode
  always_comb begin
    slot_last  = (slot == SLOT_W'(MAX_KEYS - 1));
    key_hit    = held_valid[slot] && (held_key[slot] == key_q);
    late       = now_q - repeat_due_ms[slot];
    tap_due    = repeat_valid[slot] && !late[31];
    tick_skip  = !table_changed && ((now_ms - last_tick_ms) < TICK_MIN_MS);
    period_eff = (repeat_period_ms == '0) ? 16'd1 : repeat_period_ms;
    add_entry  = ((action_q == ACT_HOLD) || (action_q == ACT_REPEAT)) && free_any;
  end

  // Find the lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = MAX_KEYS - 1; i >= 0; i--) begin
      if (!held_valid[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
    free_any = !(&held_valid);
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and result commands
  always_comb begin
    state_next = state;
    push.push  = 1'b0;
    push.flush = 1'b0;
    push.kind  = KIND_TAP;
    push.key   = key_q;
    mod_start  = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (kart_req_t'(req_type) == REQ_TICK) begin
            if (!tick_skip) begin
              state_next = S_TICK_SCAN;
            end
          end else begin
            state_next = S_REL_SCAN;
          end
        end
      end
      S_REL_SCAN: begin
        if (key_hit) begin
          push.push = 1'b1;
          push.kind = KIND_RELEASE;
        end
        if (slot_last) begin
          state_next = S_PRESS_ACT;
        end
      end
      S_PRESS_ACT: begin
        case (action_q)
          ACT_INSTANT: begin
            push.push = 1'b1;
            push.kind = KIND_TAP;
          end
          ACT_HOLD: begin
            push.push = free_any;
            push.kind = KIND_HOLD;
          end
          default: ;
        endcase
        state_next = S_FLUSH;
      end
      S_TICK_SCAN: begin
        if (tap_cnt == TAP_W'(MAX_TAPS)) begin
          state_next = S_FLUSH;
        end else if (tap_due) begin
          mod_start  = 1'b1;
          state_next = S_TICK_MOD;
        end else if (slot_last) begin
          state_next = S_FLUSH;
        end
      end
      S_TICK_MOD: begin
        if (mod_done) begin
          push.push  = 1'b1;
          push.kind  = KIND_TAP;
          push.key   = held_key[slot];
          state_next = slot_last ? S_FLUSH : S_TICK_SCAN;
        end
      end
      S_FLUSH: begin
        push.flush = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  // Control state: valid bits, tick history, walk counters, period
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid       <= '0;
      repeat_valid     <= '0;
      last_tick_ms     <= '0;
      table_changed    <= 1'b0;
      repeat_period_ms <= PERIOD_RESET;
      slot             <= '0;
      tap_cnt          <= '0;
      req_q            <= REQ_PRESS;
    end else begin
      if (cfg_wr_en) begin
        repeat_period_ms <= cfg_wr_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            req_q   <= kart_req_t'(req_type);
            slot    <= '0;
            tap_cnt <= '0;
          end
        end
        S_REL_SCAN: begin
          if (key_hit) begin
            held_valid[slot] <= 1'b0;
            if (repeat_valid[slot]) begin
              repeat_valid[slot] <= 1'b0;
              table_changed      <= 1'b1;
            end
          end
          if (!slot_last) begin
            slot <= slot + 1'b1;
          end
        end
        S_PRESS_ACT: begin
          if (add_entry) begin
            held_valid[free_idx] <= 1'b1;
            if (action_q == ACT_REPEAT) begin
              repeat_valid[free_idx] <= 1'b1;
              table_changed          <= 1'b1;
            end
          end
        end
        S_TICK_SCAN: begin
          if ((tap_cnt != TAP_W'(MAX_TAPS)) && !tap_due && !slot_last) begin
            slot <= slot + 1'b1;
          end
        end
        S_TICK_MOD: begin
          if (mod_done) begin
            tap_cnt <= tap_cnt + 1'b1;
            if (!slot_last) begin
              slot <= slot + 1'b1;
            end
          end
        end
        S_FLUSH: begin
          if (req_q == REQ_TICK) begin
            last_tick_ms  <= now_q;
            table_changed <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload: latched item, key and due-time entries
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      action_q <= kart_action_t'(press_action);
      key_q    <= key_code;
      now_q    <= now_ms;
    end
    if ((state == S_PRESS_ACT) && add_entry) begin
      held_key[free_idx] <= key_q;
      if (action_q == ACT_REPEAT) begin
        repeat_due_ms[free_idx] <= now_q;
      end
    end
    if ((state == S_TICK_MOD) && mod_done) begin
      repeat_due_ms[slot] <= repeat_due_ms[slot] + {16'd0, period_eff - mod_rem};
    end
  end

  // Shared remainder unit: lateness modulo the repeat period
  kart_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (late),
    .divisor  (period_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Output stage
  kart_out u_out (
    .clk       (clk),
    .rst       (rst),
    .cmd       (push),
    .out_valid (out_valid),
    .out_kind  (out_kind),
    .out_key   (out_key),
    .out_last  (out_last)
  );

  a_repeat_held: assert property (@(posedge clk) disable iff (rst)
    (repeat_valid & ~held_valid) == '0)
    else $error("repeating entry without a held entry");
  a_tap_limit: assert property (@(posedge clk) disable iff (rst)
    tap_cnt <= TAP_W'(MAX_TAPS))
    else $error("tick emitted too many taps");
  a_mod_done_state: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_TICK_MOD))
    else $error("remainder finished outside its wait state");

endmodule

// File: bench/key_auto_repeat_tracker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_auto_repeat_tracker_tb: self-checking bench for the key repeat tracker
// Walks a directed table of press and tick transactions, then random phases
// under several repeat periods. A key table model in the bench predicts the
// taps, holds and releases of items whose row does not type them, and each
// result strobe is compared with the oldest pending key action.
// ----------------------------------------------------------------------------
module key_auto_repeat_tracker_tb;
  import kart_pkg::*;

  localparam int NUM_KEYS      = 8;
  localparam int SETTLE_CYCLES = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_ITEMS   = 70;
  localparam int NUM_PHASES    = 6;

  typedef struct packed {
    kart_req_t    req;
    logic [7:0]   key;
    kart_action_t act;
    logic [31:0]  now;
  } key_item_t;

  typedef struct packed {
    kart_kind_t kind;
    logic [7:0] key;
    logic       last;
  } key_event_t;

  // One directed row; n_typed < 0 leaves the results to the table model
  typedef struct {
    key_item_t  item;
    int         n_typed;
    key_event_t ev0;
    key_event_t ev1;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic        req_type;
  logic [7:0]  key_code;
  logic [1:0]  press_action;
  logic [31:0] now_ms;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [7:0]  out_key;
  logic        out_last;

  key_auto_repeat_tracker #(
    .MAX_KEYS(NUM_KEYS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .key_code    (key_code),
    .press_action(press_action),
    .now_ms      (now_ms),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_kind    (out_kind),
    .out_key     (out_key),
    .out_last    (out_last)
  );

  always #4 clk = ~clk;

  // Key table model
  logic [15:0] period_ms;
  logic        held_v  [NUM_KEYS];
  logic [7:0]  held_k  [NUM_KEYS];
  logic        rep_v   [NUM_KEYS];
  logic [7:0]  rep_k   [NUM_KEYS];
  logic [31:0] rep_due [NUM_KEYS];
  logic [31:0] last_tick;
  logic        tbl_changed;

  key_event_t key_events_q[$];  // key actions still owed by the tracker
  key_event_t step_events[$];   // key actions of the latest transaction
  stim_row_t  stim_table[$];
  int         err_cnt = 0;
  int         idle_cycles = 0;

  // Advance the key table by one transaction and collect its key actions
  task automatic apply_key_item(input key_item_t it);
    key_event_t  ev;
    int          slot;
    logic [31:0] per;
    logic [31:0] late;
    step_events.delete();
    if (it.req == REQ_PRESS) begin
      // release the key first if it is held
      for (int i = 0; i < NUM_KEYS; i++) begin
        if (held_v[i] && held_k[i] == it.key) begin
          held_v[i] = 1'b0;
          ev.kind = KIND_RELEASE;
          ev.key  = it.key;
          ev.last = 1'b0;
          step_events.push_back(ev);
          if (rep_v[i]) begin
            rep_v[i]    = 1'b0;
            tbl_changed = 1'b1;
          end
        end
      end
      case (it.act)
        ACT_INSTANT: begin
          ev.kind = KIND_TAP;
          ev.key  = it.key;
          ev.last = 1'b0;
          step_events.push_back(ev);
        end
        ACT_HOLD, ACT_REPEAT: begin
          // lowest free slot; a full table drops the press silently
          slot = -1;
          for (int i = NUM_KEYS - 1; i >= 0; i--) begin
            if (!held_v[i]) slot = i;
          end
          if (slot >= 0) begin
            held_v[slot] = 1'b1;
            held_k[slot] = it.key;
            if (it.act == ACT_HOLD) begin
              ev.kind = KIND_HOLD;
              ev.key  = it.key;
              ev.last = 1'b0;
              step_events.push_back(ev);
            end else begin
              rep_v[slot]   = 1'b1;
              rep_k[slot]   = it.key;
              rep_due[slot] = it.now;
              tbl_changed   = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end else begin
      // a zero period acts as one
      per = (period_ms == 16'd0) ? 32'd1 : {16'd0, period_ms};
      if (tbl_changed || (it.now - last_tick) >= TICK_MIN_MS) begin
        // tap due keys in slot order, wrap-safe, at most MAX_TAPS of them
        for (int i = 0; i < NUM_KEYS && step_events.size() < MAX_TAPS; i++) begin
          if (rep_v[i]) begin
            late = it.now - rep_due[i];
            if (!late[31]) begin
              rep_due[i] = rep_due[i] + (per - (late % per));
              ev.kind = KIND_TAP;
              ev.key  = rep_k[i];
              ev.last = 1'b0;
              step_events.push_back(ev);
            end
          end
        end
        last_tick   = it.now;
        tbl_changed = 1'b0;
      end
    end
    // mark the final key action of the transaction
    if (step_events.size() > 0) begin
      ev = step_events.pop_back();
      ev.last = 1'b1;
      step_events.push_back(ev);
    end
  endtask

  task automatic add_row(input kart_req_t req, input logic [7:0] key,
                         input kart_action_t act, input logic [31:0] now,
                         input int n, input kart_kind_t k0, input logic [7:0] key0,
                         input kart_kind_t k1, input logic [7:0] key1);
    stim_row_t row;
    row.item.req  = req;
    row.item.key  = key;
    row.item.act  = act;
    row.item.now  = now;
    row.n_typed   = n;
    row.ev0.kind  = k0;
    row.ev0.key   = key0;
    row.ev0.last  = (n == 1);
    row.ev1.kind  = k1;
    row.ev1.key   = key1;
    row.ev1.last  = 1'b1;
    stim_table.push_back(row);
  endtask

  // Drive one transaction, hold it until taken, then log what it owes
  task automatic send_key_item(input key_item_t it, input int n_typed,
                               input key_event_t ev0, input key_event_t ev1,
                               input bit allow_gap);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_type     <= it.req;
    key_code     <= it.key;
    press_action <= it.act;
    now_ms       <= it.now;
    start        <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_key_item(it);
    if (n_typed < 0) begin
      foreach (step_events[k]) key_events_q.push_back(step_events[k]);
    end else begin
      if (n_typed >= 1) key_events_q.push_back(ev0);
      if (n_typed >= 2) key_events_q.push_back(ev1);
    end
  endtask

  // Write the repeat period once the tracker has gone quiet
  task automatic write_period(input logic [15:0] value);
    start <= 1'b0;
    while (key_events_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    period_ms = value;
  endtask

  task automatic note_mismatch(input string what, input key_event_t want,
                               input key_event_t got);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display({"mismatch (%s): expected kind %0d key %02h last %0d, ",
                "got kind %0d key %02h last %0d"},
               what, want.kind, want.key, want.last, got.kind, got.key, got.last);
  endtask

  // Check each result strobe and watch for a stalled run
  always @(posedge clk) begin : result_check
    key_event_t got;
    key_event_t want;
    if (!rst) begin
      if (out_valid) begin
        got.kind = kart_kind_t'(out_kind);
        got.key  = out_key;
        got.last = out_last;
        if (key_events_q.size() == 0) begin
          note_mismatch("no key action pending", '0, got);
        end else begin
          want = key_events_q.pop_front();
          if (got.kind !== want.kind || got.key !== want.key || got.last !== want.last)
            note_mismatch("result fields", want, got);
        end
      end
      if (out_valid || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("key_auto_repeat_tracker verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    key_item_t   it;
    key_event_t  none;
    logic [31:0] ms_now;
    logic [7:0]  pool [12];
    logic [15:0] phase_period [NUM_PHASES];
    int          roll;
    int          span;
    none = '0;
    rst          <= 1'b1;
    start        <= 1'b0;
    req_type     <= 1'b0;
    key_code     <= 8'h00;
    press_action <= 2'd0;
    now_ms       <= 32'd0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= 16'd0;
    period_ms = PERIOD_RESET;
    for (int i = 0; i < NUM_KEYS; i++) begin
      held_v[i]  = 1'b0;
      held_k[i]  = 8'h00;
      rep_v[i]   = 1'b0;
      rep_k[i]   = 8'h00;
      rep_due[i] = 32'd0;
    end
    last_tick   = 32'd0;
    tbl_changed = 1'b0;
    pool = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08,
             8'h10, 8'h20, 8'h40, 8'h80, 8'h55, 8'hAA};
    phase_period = '{16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd37, PERIOD_RESET};
    phase_period[3] = 16'($urandom_range(2, 2000));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: reset state, extremes, full table, clock wrap
    // early tick on an unchanged table is skipped
    add_row(REQ_TICK,  8'h00, ACT_INSTANT, 32'd5,   0, KIND_TAP, 8'h00, KIND_TAP, 8'h00);
    add_row(REQ_PRESS, 8'h00, ACT_INSTANT, 32'd10,  1, KIND_TAP, 8'h00, KIND_TAP, 8'h00);
    add_row(REQ_PRESS, 8'hFF, ACT_HOLD,    32'd11,  1, KIND_HOLD, 8'hFF, KIND_TAP, 8'h00);
    // re-press of a held key releases it first
    add_row(REQ_PRESS, 8'hFF, ACT_INSTANT, 32'd12,  2, KIND_RELEASE, 8'hFF, KIND_TAP, 8'hFF);
    add_row(REQ_PRESS, 8'hFF, ACT_RELEASE, 32'd13,  0, KIND_TAP, 8'h00, KIND_TAP, 8'h00);
    add_row(REQ_PRESS, 8'h5A, ACT_REPEAT,  32'd100, 0, KIND_TAP, 8'h00, KIND_TAP, 8'h00);
    add_row(REQ_TICK,  8'hFF, ACT_RELEASE, 32'd100, 1, KIND_TAP, 8'h5A, KIND_TAP, 8'h00);
    add_row(REQ_TICK,  8'h00, ACT_INSTANT, 32'd110, 0, KIND_TAP, 8'h00, KIND_TAP, 8'h00);
    add_row(REQ_TICK,  8'hA5, ACT_HOLD,    32'd199, -1, KIND_TAP, 8'h00, KIND_TAP, 8'h00);
    add_row(REQ_TICK,  8'h5A, ACT_REPEAT,  32'd250, -1, KIND_TAP, 8'h00, KIND_TAP, 8'h00);
    add_row(REQ_PRESS, 8'h5A, ACT_RELEASE, 32'd260, 1, KIND_RELEASE, 8'h5A, KIND_TAP, 8'h00);
    // fill every slot with holds and repeating keys
    add_row(REQ_PRESS, 8'h01, ACT_HOLD,    32'd270, 1, KIND_HOLD, 8'h01, KIND_TAP, 8'h00);
    add_row(REQ_PRESS, 8'h02, ACT_HOLD,    32'd280, 1, KIND_HOLD, 8'h02, KIND_TAP, 8'h00);
    add_row(REQ_PRESS, 8'h03, ACT_HOLD,    32'd290, 1, KIND_HOLD, 8'h03, KIND_TAP, 8'h00);
    add_row(REQ_PRESS, 8'h80, ACT_REPEAT,  32'd300, 0, KIND_TAP, 8'h00, KIND_TAP, 8'h00);
    add_row(REQ_PRESS, 8'h81, ACT_REPEAT,  32'd301, 0, KIND_TAP, 8'h00, KIND_TAP, 8'h00);
    add_row(REQ_PRESS, 8'h82, ACT_REPEAT,  32'd302, 0, KIND_TAP, 8'h00, KIND_TAP, 8'h00);
    add_row(REQ_PRESS, 8'h83, ACT_REPEAT,  32'd303, 0, KIND_TAP, 8'h00, KIND_TAP, 8'h00);
    add_row(REQ_PRESS, 8'h84, ACT_REPEAT,  32'd304, 0, KIND_TAP, 8'h00, KIND_TAP, 8'h00);
    // full table drops a new hold
    add_row(REQ_PRESS, 8'h33, ACT_HOLD,    32'd305, 0, KIND_TAP, 8'h00, KIND_TAP, 8'h00);
    add_row(REQ_TICK,  8'h00, ACT_HOLD,    32'd1000, -1, KIND_TAP, 8'h00, KIND_TAP, 8'h00);
    // far-future tick: every due time reads as ahead
    add_row(REQ_TICK,  8'hFF, ACT_REPEAT,  32'h9000_0000, -1, KIND_TAP, 8'h00, KIND_TAP, 8'h00);
    add_row(REQ_PRESS, 8'h02, ACT_RELEASE, 32'h9000_0001, 1, KIND_RELEASE, 8'h02,
            KIND_TAP, 8'h00);
    // repeating key set just before the clock wraps, due just after
    add_row(REQ_PRESS, 8'hC3, ACT_REPEAT,  32'hFFFF_FFF0, 0, KIND_TAP, 8'h00, KIND_TAP, 8'h00);
    add_row(REQ_TICK,  8'h3C, ACT_INSTANT, 32'h0000_0010, -1, KIND_TAP, 8'h00, KIND_TAP, 8'h00);

    foreach (stim_table[r])
      send_key_item(stim_table[r].item, stim_table[r].n_typed, stim_table[r].ev0,
                    stim_table[r].ev1, 1'b1);

    // Random phases, one repeat period each
    ms_now = 32'd2000;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_period(phase_period[p]);
      if (p == 2) ms_now = 32'hFFFF_FC00;
      span = (phase_period[p] > 16'd300) ? int'(phase_period[p]) : 150;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll   = $urandom_range(0, 99);
        it.key = pool[$urandom_range(0, 11)];
        if ($urandom_range(0, 6) == 0) it.key = 8'($urandom_range(0, 255));
        it.act = kart_action_t'($urandom_range(0, 3));
        if (roll < 45) begin
          // key press on a slowly advancing clock
          it.req = REQ_PRESS;
          ms_now = ms_now + $urandom_range(0, 5);
          it.now = ms_now;
        end else if (roll < 94) begin
          // tick: short steps probe the skip window, long ones the repeats
          it.req = REQ_TICK;
          case ($urandom_range(0, 3))
            0:       ms_now = ms_now + $urandom_range(0, 25);
            3:       ms_now = ms_now + $urandom_range(0, 3 * span);
            default: ms_now = ms_now + $urandom_range(0, span);
          endcase
          it.now = ms_now;
        end else begin
          // noise: any kind at any clock value
          it.req = kart_req_t'($urandom_range(0, 1));
          it.now = $urandom();
          if (roll == 99) ms_now = it.now;
        end
        send_key_item(it, -1, none, none, p < NUM_PHASES - 1);
      end
    end

    // Drain and settle
    start <= 1'b0;
    while (key_events_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("key_auto_repeat_tracker verification clean");
    end else begin
      $display("key_auto_repeat_tracker verification failed");
    end
    $finish;
  end

endmodule
